// ===== rtl/swbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package swbb_pkg;

    // Function codes of an input item.
    typedef enum logic [2:0] {
        FN_CHARGE   = 3'd0,
        FN_HOLD     = 3'd1,
        FN_RELEASE  = 3'd2,
        FN_PART     = 3'd3,
        FN_REFUND   = 3'd4,
        FN_QUERY    = 3'd5,
        FN_WADD     = 3'd6,
        FN_WREMOVE  = 3'd7
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Configuration register indexes.
    localparam logic [0:0] CFG_SHARE  = 1'b0;
    localparam logic [0:0] CFG_WINDOW = 1'b1;

    // One request as it travels from the front queue to the engine.
    typedef struct packed {
        t_func       func;
        logic [31:0] amount;
        logic [1:0]  prio;
        logic [47:0] time_now;
        logic [31:0] ticket_id;
    } t_req;

    // One result as it travels from the engine to the output queue.
    typedef struct packed {
        t_status     status;
        logic [31:0] new_ticket;
        logic [31:0] in_window;
    } t_rsp;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/swbb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-entry register queue; used for both the request and the result side.
module swbb_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_data    = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_do_push) r_wptr <= ~r_wptr;
            if (w_do_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, w_do_push} - {1'b0, w_do_pop};
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wptr] <= i_data;
    end
endmodule
`default_nettype wire

// ===== rtl/swbb_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Executes one request: scans the slot table one entry per cycle, then
// decides and writes back.
module swbb_engine #(
    parameter int TABLE_DEPTH    = 16,
    parameter int NUM_PRIORITIES = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_share,
    input  wire logic [31:0]   i_window,
    input  wire logic          i_req_avail,
    input  wire swbb_pkg::t_req i_req,
    output logic               o_req_take,
    input  wire logic          i_rsp_full,
    output logic               o_rsp_push,
    output swbb_pkg::t_rsp     o_rsp
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    swbb_pkg::t_state r_state, n_state;
    swbb_pkg::t_req   r_req;
    logic [CW-1:0]    r_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [31:0]      r_slot_id    [TABLE_DEPTH];
    logic             r_slot_open  [TABLE_DEPTH];
    logic [47:0]      r_slot_end   [TABLE_DEPTH];
    logic [31:0]      r_slot_bytes [TABLE_DEPTH];
    logic [7:0]       r_waiter [NUM_PRIORITIES];
    logic [31:0]      r_id_counter;
    logic [32:0]      r_sum;
    logic             r_found;
    logic [IW-1:0]    r_match;
    logic             r_free_ok;
    logic [IW-1:0]    r_free;
    logic             r_early;
    swbb_pkg::t_rsp   r_rsp;

    logic [IW-1:0]    w_i;
    logic             w_scan_sum;
    logic             w_expired;
    logic [48:0]      w_limit;
    logic             w_urgent;
    logic             w_refuse;
    logic [32:0]      w_total;
    logic [31:0]      w_mbytes;
    logic [31:0]      w_part;
    logic             w_do_take;
    logic             w_do_part;

    assign w_i        = r_idx[IW-1:0];
    assign w_scan_sum = (r_req.func == swbb_pkg::FN_CHARGE) ||
                        (r_req.func == swbb_pkg::FN_HOLD) ||
                        (r_req.func == swbb_pkg::FN_QUERY);
    assign w_limit    = {1'b0, r_slot_end[w_i]} + {17'd0, i_window};
    assign w_expired  = !r_slot_open[w_i] && (w_limit <= {1'b0, r_req.time_now});
    assign w_mbytes   = r_slot_bytes[r_match];
    assign w_part     = (r_req.amount < w_mbytes) ? r_req.amount : w_mbytes;
    assign w_total    = {1'b0, r_rsp.in_window} + {1'b0, r_req.amount};

    // A more urgent waiter exists.
    always_comb begin
        w_urgent = 1'b0;
        for (int p = 0; p < NUM_PRIORITIES; p++) begin
            if ((p < 4) && (2'(p) < r_req.prio) && (r_waiter[p] != 8'd0)) w_urgent = 1'b1;
        end
    end

    // A charge or hold that is refused before any entry is looked at.
    assign w_refuse = (r_idx == '0) &&
                      ((r_req.func == swbb_pkg::FN_CHARGE) ||
                       (r_req.func == swbb_pkg::FN_HOLD)) &&
                      ((r_req.amount > i_share) || w_urgent);

    // Next state and handshakes.
    always_comb begin
        n_state    = r_state;
        o_req_take = 1'b0;
        o_rsp_push = 1'b0;
        case (r_state)
            swbb_pkg::S_IDLE: begin
                if (i_req_avail) begin
                    o_req_take = 1'b1;
                    n_state    = swbb_pkg::S_SCAN;
                end
            end
            swbb_pkg::S_SCAN: begin
                if (r_early || (r_idx == CW'(TABLE_DEPTH - 1))) n_state = swbb_pkg::S_DECIDE;
            end
            swbb_pkg::S_DECIDE: n_state = swbb_pkg::S_WRITE;
            swbb_pkg::S_WRITE:  n_state = swbb_pkg::S_DONE;
            swbb_pkg::S_DONE: begin
                if (!i_rsp_full) begin
                    o_rsp_push = 1'b1;
                    n_state    = swbb_pkg::S_IDLE;
                end
            end
            default: n_state = swbb_pkg::S_IDLE;
        endcase
    end

    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= swbb_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Control state: valid bits, id counter, waiter counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_id_counter <= 32'd0;
            for (int p = 0; p < NUM_PRIORITIES; p++) r_waiter[p] <= 8'd0;
        end else begin
            if ((r_state == swbb_pkg::S_SCAN) && !r_early && !w_refuse && w_scan_sum &&
                r_valid[w_i] && w_expired) begin
                r_valid[w_i] <= 1'b0;
            end
            if ((r_state == swbb_pkg::S_WRITE) && (w_do_take || w_do_part)) begin
                r_valid[r_free] <= 1'b1;
                r_id_counter    <= r_id_counter + 32'd1;
            end
            if (r_state == swbb_pkg::S_DECIDE) begin
                for (int p = 0; p < NUM_PRIORITIES; p++) begin
                    if ((p < 4) && (2'(p) == r_req.prio)) begin
                        if ((r_req.func == swbb_pkg::FN_WADD) && (r_waiter[p] != 8'hFF))
                            r_waiter[p] <= r_waiter[p] + 8'd1;
                        if ((r_req.func == swbb_pkg::FN_WREMOVE) && (r_waiter[p] != 8'd0))
                            r_waiter[p] <= r_waiter[p] - 8'd1;
                    end
                end
            end
        end
    end

    // Datapath: request capture, scan accumulation, decision and writeback.
    always_ff @(posedge i_clk) begin
        case (r_state)
            swbb_pkg::S_IDLE: begin
                r_req     <= i_req;
                r_idx     <= '0;
                r_sum     <= '0;
                r_found   <= 1'b0;
                r_match   <= '0;
                r_free_ok <= 1'b0;
                r_free    <= '0;
                r_early   <= 1'b0;
                r_rsp     <= '0;
            end
            swbb_pkg::S_SCAN: begin
                if (w_refuse) begin
                    r_early <= 1'b1;
                end else begin
                    r_idx <= r_idx + CW'(1);
                    if (r_valid[w_i] && !(w_scan_sum && w_expired)) begin
                        if (r_sum[32] == 1'b0)
                            r_sum <= r_sum + {1'b0, r_slot_bytes[w_i]};
                        if (!r_found && (r_slot_id[w_i] == r_req.ticket_id)) begin
                            r_found <= 1'b1;
                            r_match <= w_i;
                        end
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= w_i;
                    end
                end
            end
            swbb_pkg::S_DECIDE: begin
                r_rsp.in_window <= r_sum[32] ? 32'hFFFF_FFFF : r_sum[31:0];
            end
            swbb_pkg::S_WRITE: begin
                case (r_req.func)
                    swbb_pkg::FN_CHARGE, swbb_pkg::FN_HOLD: begin
                        if (r_early) begin
                            r_rsp.status    <= swbb_pkg::ST_REFUSED;
                            r_rsp.in_window <= 32'd0;
                        end else if (w_total > {1'b0, i_share}) begin
                            r_rsp.status <= swbb_pkg::ST_REFUSED;
                        end else if (!r_free_ok) begin
                            r_rsp.status <= swbb_pkg::ST_FULL;
                        end else begin
                            r_rsp.new_ticket        <= r_id_counter;
                            r_slot_id[r_free]       <= r_id_counter;
                            r_slot_open[r_free]     <= (r_req.func == swbb_pkg::FN_HOLD);
                            r_slot_end[r_free]      <= (r_req.func == swbb_pkg::FN_HOLD) ?
                                                       48'd0 : r_req.time_now;
                            r_slot_bytes[r_free]    <= r_req.amount;
                        end
                    end
                    swbb_pkg::FN_RELEASE: begin
                        r_rsp.in_window <= 32'd0;
                        if (!r_found) r_rsp.status <= swbb_pkg::ST_NOTFOUND;
                        else begin
                            r_slot_open[r_match] <= 1'b0;
                            r_slot_end[r_match]  <= r_req.time_now;
                        end
                    end
                    swbb_pkg::FN_PART: begin
                        r_rsp.in_window <= 32'd0;
                        if (!r_found) r_rsp.status <= swbb_pkg::ST_NOTFOUND;
                        else if (!r_free_ok) r_rsp.status <= swbb_pkg::ST_FULL;
                        else begin
                            r_slot_bytes[r_match] <= w_mbytes - w_part;
                            r_rsp.new_ticket      <= r_id_counter;
                            r_slot_id[r_free]     <= r_id_counter;
                            r_slot_open[r_free]   <= 1'b0;
                            r_slot_end[r_free]    <= r_req.time_now;
                            r_slot_bytes[r_free]  <= w_part;
                        end
                    end
                    swbb_pkg::FN_REFUND: begin
                        r_rsp.in_window <= 32'd0;
                        if (!r_found) r_rsp.status <= swbb_pkg::ST_NOTFOUND;
                        else r_slot_bytes[r_match] <= w_mbytes - w_part;
                    end
                    swbb_pkg::FN_QUERY: ;
                    default: r_rsp.in_window <= 32'd0;
                endcase
            end
            default: ;
        endcase
    end

    // Take flags for the counter update, evaluated in the write cycle.
    always_comb begin
        w_do_take = 1'b0;
        w_do_part = 1'b0;
        if ((r_req.func == swbb_pkg::FN_CHARGE) || (r_req.func == swbb_pkg::FN_HOLD))
            w_do_take = !r_early && !(w_total > {1'b0, i_share}) && r_free_ok;
        if (r_req.func == swbb_pkg::FN_PART)
            w_do_part = r_found && r_free_ok;
    end
endmodule
`default_nettype wire

// ===== rtl/sliding_window_byte_budget.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: the engine takes a request, scans the slot table one slot per cycle
// (a charge or hold refused up front ends the scan at once), decides, writes
// back and pushes the result, waiting while the result queue is full; it takes
// no new request until that result is pushed. Two-entry queue each side.
// Reset: synchronous active low; clears slots, id counter and waiter counts,
// and loads share 65536 and window 1000.
module sliding_window_byte_budget #(
    parameter int TABLE_DEPTH    = 16,
    parameter int NUM_PRIORITIES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_amount,
    input  wire logic [1:0]  i_priority_req,
    input  wire logic [47:0] i_time_now,
    input  wire logic [31:0] i_ticket_id,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic [31:0]      o_new_ticket,
    output logic [31:0]      o_in_window,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int REQ_W = $bits(swbb_pkg::t_req);
    localparam int RSP_W = $bits(swbb_pkg::t_rsp);

    logic [31:0]     r_share;
    logic [31:0]     r_window;
    swbb_pkg::t_req  w_in_req;
    swbb_pkg::t_req  w_q_req;
    swbb_pkg::t_rsp  w_e_rsp;
    swbb_pkg::t_rsp  w_o_rsp;
    logic            w_req_empty;
    logic            w_req_take;
    logic            w_rsp_full;
    logic            w_rsp_push;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_share  <= 32'd65536;
            r_window <= 32'd1000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == swbb_pkg::CFG_SHARE)  r_share  <= i_cfg_data;
            if (i_cfg_index == swbb_pkg::CFG_WINDOW) r_window <= i_cfg_data;
        end
    end

    assign w_in_req.func      = swbb_pkg::t_func'(i_func);
    assign w_in_req.amount    = i_amount;
    assign w_in_req.prio      = i_priority_req;
    assign w_in_req.time_now  = i_time_now;
    assign w_in_req.ticket_id = i_ticket_id;

    // Front: request queue.
    swbb_fifo #(.WIDTH(REQ_W)) u_req_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(w_in_req), .o_full(full),
        .i_pop(w_req_take), .o_empty(w_req_empty), .o_data(w_q_req)
    );

    // Back: table engine.
    swbb_engine #(.TABLE_DEPTH(TABLE_DEPTH), .NUM_PRIORITIES(NUM_PRIORITIES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_share(r_share), .i_window(r_window),
        .i_req_avail(!w_req_empty), .i_req(w_q_req), .o_req_take(w_req_take),
        .i_rsp_full(w_rsp_full), .o_rsp_push(w_rsp_push), .o_rsp(w_e_rsp)
    );

    // Result queue.
    swbb_fifo #(.WIDTH(RSP_W)) u_rsp_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_rsp_push), .i_data(w_e_rsp), .o_full(w_rsp_full),
        .i_pop(pop), .o_empty(empty), .o_data(w_o_rsp)
    );

    assign o_status     = w_o_rsp.status;
    assign o_new_ticket = w_o_rsp.new_ticket;
    assign o_in_window  = w_o_rsp.in_window;
endmodule
`default_nettype wire

// ===== tb/sliding_window_byte_budget_tb.sv =====
`timescale 1ns / 1ps
module sliding_window_byte_budget_tb;

    localparam int DEPTH = 16;
    localparam int NPRIO = 4;
    localparam int DRAIN_CYCLES = 64;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_func = '0;
    logic [31:0] i_amount = '0;
    logic [1:0]  i_priority_req = '0;
    logic [47:0] i_time_now = '0;
    logic [31:0] i_ticket_id = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_new_ticket;
    logic [31:0] o_in_window;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    sliding_window_byte_budget dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_func(i_func), .i_amount(i_amount), .i_priority_req(i_priority_req),
        .i_time_now(i_time_now), .i_ticket_id(i_ticket_id),
        .empty(empty), .pop(pop),
        .o_status(o_status), .o_new_ticket(o_new_ticket), .o_in_window(o_in_window),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the budget table and settings.
    logic [31:0] sh_share;
    logic [31:0] sh_window;
    logic        tb_valid [DEPTH];
    logic [31:0] tb_id [DEPTH];
    logic        tb_open [DEPTH];
    logic [47:0] tb_end [DEPTH];
    logic [31:0] tb_bytes [DEPTH];
    logic [31:0] next_id;
    logic [7:0]  waiters [NPRIO];

    swbb_pkg::t_rsp pending_rsp [$];
    logic [31:0] issued_ids [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    longint      cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;

    // Drops expired closed entries and returns the saturated live byte sum.
    function automatic logic [31:0] live_bytes(input logic [47:0] now);
        logic [63:0] acc;
        acc = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (tb_valid[i]) begin
                if (!tb_open[i] && ({16'd0, tb_end[i]} + {32'd0, sh_window}) <= {16'd0, now})
                    tb_valid[i] = 1'b0;
                else
                    acc += tb_bytes[i];
            end
        end
        return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < DEPTH; i++)
            if (!tb_valid[i]) return i;
        return -1;
    endfunction

    function automatic int slot_of(input logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (tb_valid[i] && tb_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void open_entry(input int s, input logic is_open,
                                       input logic [47:0] t, input logic [31:0] b);
        tb_valid[s] = 1'b1;
        tb_id[s] = next_id;
        tb_open[s] = is_open;
        tb_end[s] = is_open ? 48'd0 : t;
        tb_bytes[s] = b;
        issued_ids.insert(issued_ids.size(), next_id);
        if (issued_ids.size() > 32) void'(issued_ids.pop_front());
        next_id = next_id + 32'd1;
    endfunction

    // Works out the result of one request and updates the shadow state.
    function automatic swbb_pkg::t_rsp budget_step(input swbb_pkg::t_func f,
                                                   input logic [31:0] amt,
                                                   input logic [1:0] pr,
                                                   input logic [47:0] now,
                                                   input logic [31:0] tk);
        swbb_pkg::t_rsp r;
        int s, fr;
        logic urgent;
        logic [31:0] part;
        r.status = swbb_pkg::ST_OK;
        r.new_ticket = '0;
        r.in_window = '0;
        urgent = 1'b0;
        for (int p = 0; p < NPRIO; p++)
            if (p < pr && waiters[p] != 0) urgent = 1'b1;
        case (f)
            swbb_pkg::FN_CHARGE, swbb_pkg::FN_HOLD: begin
                if (amt > sh_share || urgent) begin
                    r.status = swbb_pkg::ST_REFUSED;
                end else begin
                    r.in_window = live_bytes(now);
                    if ({32'd0, r.in_window} + {32'd0, amt} > {32'd0, sh_share}) begin
                        r.status = swbb_pkg::ST_REFUSED;
                    end else begin
                        fr = free_slot();
                        if (fr < 0) begin
                            r.status = swbb_pkg::ST_FULL;
                        end else begin
                            r.new_ticket = next_id;
                            open_entry(fr, f == swbb_pkg::FN_HOLD, now, amt);
                        end
                    end
                end
            end
            swbb_pkg::FN_RELEASE: begin
                s = slot_of(tk);
                if (s < 0) begin
                    r.status = swbb_pkg::ST_NOTFOUND;
                end else begin
                    tb_open[s] = 1'b0;
                    tb_end[s] = now;
                end
            end
            swbb_pkg::FN_PART: begin
                s = slot_of(tk);
                fr = free_slot();
                if (s < 0) begin
                    r.status = swbb_pkg::ST_NOTFOUND;
                end else if (fr < 0) begin
                    r.status = swbb_pkg::ST_FULL;
                end else begin
                    part = (amt < tb_bytes[s]) ? amt : tb_bytes[s];
                    tb_bytes[s] -= part;
                    r.new_ticket = next_id;
                    open_entry(fr, 1'b0, now, part);
                end
            end
            swbb_pkg::FN_REFUND: begin
                s = slot_of(tk);
                if (s < 0) r.status = swbb_pkg::ST_NOTFOUND;
                else tb_bytes[s] -= (amt < tb_bytes[s]) ? amt : tb_bytes[s];
            end
            swbb_pkg::FN_QUERY: r.in_window = live_bytes(now);
            swbb_pkg::FN_WADD: if (waiters[pr] != 8'd255) waiters[pr]++;
            default: if (waiters[pr] != 8'd0) waiters[pr]--;
        endcase
        return r;
    endfunction

    // Sends one request, with random gaps before it, and records its result.
    task automatic send_request(input swbb_pkg::t_func f, input logic [31:0] amt,
                                input logic [1:0] pr, input logic [47:0] now,
                                input logic [31:0] tk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_func <= f;
        i_amount <= amt;
        i_priority_req <= pr;
        i_time_now <= now;
        i_ticket_id <= tk;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_rsp.insert(pending_rsp.size(), budget_step(f, amt, pr, now, tk));
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == swbb_pkg::CFG_SHARE) sh_share = val;
        else sh_window = val;
        @(posedge i_clk);
    endtask

    // Receiver: pops at random, or holds off for a counted stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checks each popped result against the oldest expectation.
    always @(posedge i_clk) begin
        swbb_pkg::t_rsp want;
        cycles <= cycles + 1;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d ticket %0d window %0d",
                             o_status, o_new_ticket, o_in_window);
            end else begin
                want = pending_rsp.pop_front();
                if (o_status !== want.status || o_new_ticket !== want.new_ticket ||
                    o_in_window !== want.in_window) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d tk %0d win %0d, got st %0d tk %0d win %0d",
                                 want.status, want.new_ticket, want.in_window,
                                 o_status, o_new_ticket, o_in_window);
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_rsp.size());
            $display("sliding_window_byte_budget_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick_ticket();
        if (issued_ids.size() != 0 && $urandom_range(9) < 8)
            return issued_ids[$urandom_range(issued_ids.size() - 1)];
        return $urandom();
    endfunction

    // Extremes of every field, every function and the listed corner cases.
    task automatic test_directed();
        send_request(swbb_pkg::FN_QUERY, 32'd0, 2'd0, 48'd0, 32'd0);
        send_request(swbb_pkg::FN_CHARGE, 32'd65537, 2'd0, 48'd10, 32'd0);
        send_request(swbb_pkg::FN_CHARGE, 32'd1000, 2'd3, 48'd10, 32'd0);
        send_request(swbb_pkg::FN_HOLD, 32'd64536, 2'd0, 48'd20, 32'd0);
        send_request(swbb_pkg::FN_CHARGE, 32'd1, 2'd0, 48'd30, 32'd0);
        send_request(swbb_pkg::FN_RELEASE, 32'd0, 2'd0, 48'd40, 32'd1);
        send_request(swbb_pkg::FN_RELEASE, 32'd0, 2'd0, 48'd40, 32'hFFFF_FFFF);
        send_request(swbb_pkg::FN_PART, 32'd500, 2'd1, 48'd50, 32'd1);
        send_request(swbb_pkg::FN_PART, 32'hFFFF_FFFF, 2'd1, 48'd60, 32'd0);
        send_request(swbb_pkg::FN_REFUND, 32'd100, 2'd2, 48'd60, 32'd1);
        send_request(swbb_pkg::FN_REFUND, 32'hFFFF_FFFF, 2'd2, 48'd60, 32'd2);
        send_request(swbb_pkg::FN_REFUND, 32'd5, 2'd2, 48'd60, 32'd77);
        send_request(swbb_pkg::FN_QUERY, 32'd0, 2'd3, 48'd1039, 32'd0);
        send_request(swbb_pkg::FN_QUERY, 32'd0, 2'd3, 48'd1040, 32'd0);
        send_request(swbb_pkg::FN_WADD, 32'd0, 2'd1, 48'd0, 32'd0);
        send_request(swbb_pkg::FN_CHARGE, 32'd10, 2'd2, 48'd1100, 32'd0);
        send_request(swbb_pkg::FN_CHARGE, 32'd10, 2'd1, 48'd1100, 32'd0);
        send_request(swbb_pkg::FN_WREMOVE, 32'd0, 2'd1, 48'd0, 32'd0);
        send_request(swbb_pkg::FN_WREMOVE, 32'd0, 2'd1, 48'd0, 32'd0);
        send_request(swbb_pkg::FN_WADD, 32'd0, 2'd0, 48'd0, 32'd0);
        send_request(swbb_pkg::FN_WREMOVE, 32'd0, 2'd0, 48'hFFFF_FFFF_FFFF, 32'd0);
        send_request(swbb_pkg::FN_QUERY, 32'd0, 2'd0, 48'hFFFF_FFFF_FFFF, 32'd0);
        wait_drained();
    endtask

    // Fills the table with small holds, then overflows it.
    task automatic test_table_full();
        write_reg(swbb_pkg::CFG_SHARE, 32'hFFFF_FFFF);
        write_reg(swbb_pkg::CFG_WINDOW, 32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(swbb_pkg::FN_HOLD, 32'd8 >> (i % 2), 2'd0, 48'd2000 + 48'(i),
                         32'd0);
        send_request(swbb_pkg::FN_PART, 32'd1, 2'd0, 48'd2100, pick_ticket());
        send_request(swbb_pkg::FN_QUERY, 32'd0, 2'd0, 48'd2100, 32'd0);
        for (int i = 0; i < DEPTH; i++)
            send_request(swbb_pkg::FN_RELEASE, 32'd0, 2'd0, 48'd0,
                         next_id - 32'd1 - 32'(i));
        wait_drained();
        write_reg(swbb_pkg::CFG_WINDOW, 32'd0);
        send_request(swbb_pkg::FN_QUERY, 32'd0, 2'd0, 48'd0, 32'd0);
        send_request(swbb_pkg::FN_QUERY, 32'd0, 2'd0, 48'd1, 32'd0);
        wait_drained();
    endtask

    // Waiter counter saturation at the top and at the bottom.
    task automatic test_waiter_saturation();
        for (int i = 0; i < 257; i++) begin
            send_idle_pct = 0;
            send_request(swbb_pkg::FN_WADD, $urandom(), 2'd2, 48'($urandom()), $urandom());
        end
        send_request(swbb_pkg::FN_CHARGE, 32'd1, 2'd3, 48'd5, 32'd0);
        for (int i = 0; i < 256; i++)
            send_request(swbb_pkg::FN_WREMOVE, $urandom(), 2'd2, 48'($urandom()),
                         $urandom());
        wait_drained();
    endtask

    // One random request, mostly table traffic around a moving clock.
    task automatic random_request(inout logic [47:0] clock_now);
        int k;
        logic [31:0] amt;
        logic [47:0] t;
        logic [1:0]  pr;
        k = $urandom_range(99);
        clock_now += $urandom_range(sh_window > 8 ? 8 : 1);
        t = ($urandom_range(49) == 0) ? 48'({$urandom(), $urandom()}) : clock_now;
        amt = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(sh_share / 8 + 1);
        pr = 2'($urandom());
        if (k < 30)      send_request(swbb_pkg::FN_CHARGE, amt, pr, t, $urandom());
        else if (k < 45) send_request(swbb_pkg::FN_HOLD, amt, pr, t, $urandom());
        else if (k < 60) send_request(swbb_pkg::FN_RELEASE, $urandom(), pr, t, pick_ticket());
        else if (k < 70) send_request(swbb_pkg::FN_PART, amt, pr, t, pick_ticket());
        else if (k < 80) send_request(swbb_pkg::FN_REFUND, amt, pr, t, pick_ticket());
        else if (k < 90) send_request(swbb_pkg::FN_QUERY, $urandom(), pr, t, $urandom());
        else if (k < 95) send_request(swbb_pkg::FN_WADD, $urandom(), pr, t, $urandom());
        else             send_request(swbb_pkg::FN_WREMOVE, $urandom(), pr, t, $urandom());
    endtask

    task automatic write_phase_break();
        wait_drained();
        write_reg(swbb_pkg::CFG_SHARE, 32'd3000);
    endtask

    // Random traffic in three idling phases, each with its own settings.
    task automatic test_random_phases();
        logic [47:0] clock_now;
        clock_now = 48'd10000;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 33; recv_idle_pct = 84;
                    write_reg(swbb_pkg::CFG_SHARE, 32'd5000);
                    write_reg(swbb_pkg::CFG_WINDOW, 32'd40);
                end
                1: begin
                    send_idle_pct = 84; recv_idle_pct = 33;
                    write_reg(swbb_pkg::CFG_SHARE, 32'd0);
                    write_reg(swbb_pkg::CFG_WINDOW, 32'd1);
                end
                default: begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                    write_reg(swbb_pkg::CFG_SHARE, $urandom());
                    write_reg(swbb_pkg::CFG_WINDOW, 32'd200);
                end
            endcase
            for (int n = 0; n < 35; n++) begin
                if (ph == 1 && n == 17) write_phase_break();
                random_request(clock_now);
            end
            wait_drained();
        end
    endtask

    // Receiver stalls for a long stretch while requests keep coming.
    task automatic test_backpressure();
        logic [47:0] clock_now;
        clock_now = 48'd500000;
        send_idle_pct = 0;
        write_reg(swbb_pkg::CFG_SHARE, 32'd65536);
        write_reg(swbb_pkg::CFG_WINDOW, 32'd1000);
        hold_off = 400;
        for (int n = 0; n < 20; n++) random_request(clock_now);
        wait_drained();
    endtask

    initial begin
        sh_share = 32'd65536;
        sh_window = 32'd1000;
        next_id = '0;
        for (int i = 0; i < DEPTH; i++) tb_valid[i] = 1'b0;
        for (int p = 0; p < NPRIO; p++) waiters[p] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 20;
        recv_idle_pct = 20;
        test_directed();
        test_table_full();
        test_waiter_saturation();
        test_random_phases();
        test_backpressure();
        $display("Sent %0d items, checked %0d results, %0d mismatches.",
                 items_sent, results_seen, mismatches);
        $display("Covered all functions, full table, waiter limits, window extremes, stalls.");
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("sliding_window_byte_budget_tb OK");
        else
            $display("sliding_window_byte_budget_tb NOT OK");
        $finish;
    end
endmodule
